// ===== hdl/iop_pkg.sv =====
`default_nettype none
package iop_pkg;

	localparam int LAYER_W = 10;
	localparam int SIZE_W  = 32;
	localparam int OFS_W   = 40;
	localparam int ERR_W   = 2;

	localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
	localparam logic [ERR_W-1:0] ERR_REVERSED = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FULL     = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [LAYER_W-1:0] lo;
		logic [LAYER_W-1:0] hi;
		logic [OFS_W-1:0]   base;
		logic [OFS_W-1:0]   top;
	} entry_t;

	typedef struct packed {
		logic             tok;
		logic             stop;
		logic [OFS_W-1:0] cand;
	} scan_t;

	typedef struct packed {
		logic             clr;
		logic             ins;
		logic [OFS_W-1:0] ins_cand;
	} cell_ctl_t;

	function automatic logic [OFS_W-1:0] sat_add(input logic [OFS_W-1:0] a,
		input logic [SIZE_W-1:0] b);
		logic [OFS_W:0] s;
		s = {1'b0, a} + {{(OFS_W + 1 - SIZE_W){1'b0}}, b};
		return s[OFS_W] ? {OFS_W{1'b1}} : s[OFS_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/iop_cell.sv =====
`default_nettype none
module iop_cell
	import iop_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cell_ctl_t          ctl,
	input  wire entry_t             new_entry,
	input  wire logic [LAYER_W-1:0] item_lo,
	input  wire logic [LAYER_W-1:0] item_hi,
	input  wire logic [SIZE_W-1:0]  item_size,
	input  wire scan_t              scan_in,
	output scan_t                   scan_out,
	input  wire entry_t             prev_entry,
	input  wire logic               prev_valid,
	input  wire logic               prev_keep,
	output entry_t                  entry,
	output logic                    valid,
	output logic                    keep
);

	entry_t           entry_q;
	logic             valid_q;
	logic             scan_tok_q;
	logic             scan_stop_q;
	logic [OFS_W-1:0] scan_cand_q;
	logic             overlap;
	logic [OFS_W-1:0] fit_end;

	assign entry = entry_q;
	assign valid = valid_q;
	assign scan_out = '{tok: scan_tok_q, stop: scan_stop_q, cand: scan_cand_q};
	assign keep = valid_q && (entry_q.base < ctl.ins_cand);

	assign overlap = valid_q && (item_lo <= entry_q.hi) && (item_hi >= entry_q.lo);
	assign fit_end = sat_add(scan_in.cand, item_size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			scan_tok_q <= 1'b0;
			scan_stop_q <= 1'b0;
		end else begin
			scan_tok_q <= scan_in.tok;
			scan_stop_q <= scan_in.stop;
			if (scan_in.tok && !scan_in.stop && overlap && fit_end <= entry_q.base) begin
				scan_stop_q <= 1'b1;
			end
			if (ctl.clr) begin
				valid_q <= 1'b0;
			end else if (ctl.ins && !keep) begin
				valid_q <= prev_keep ? 1'b1 : prev_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_cand_q <= scan_in.cand;
		if (scan_in.tok && !scan_in.stop && overlap && fit_end > entry_q.base
			&& entry_q.top > scan_in.cand) begin
			scan_cand_q <= entry_q.top;
		end
		if (ctl.ins && !keep) begin
			entry_q <= prev_keep ? new_entry : prev_entry;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/interval_offset_planner.sv =====
`default_nettype none
// Greedy buffer offset planner. One item is one buffer lifetime; one result
// comes back per item. Placed entries sit sorted by base offset in a row of
// MAX_ENTRIES cells; the candidate offset walks the row one cell per cycle,
// then a stored placement is inserted by one shift of the whole row.
// Reversed, zero-size and table-full items skip the scan and go straight
// to the result. tuser[0] of the input starts a new plan.
module interval_offset_planner
	import iop_pkg::*;
#(
	parameter int MAX_ENTRIES = 256,
	parameter int MAX_LAYERS  = 1024,
	parameter int SIZE_BITS   = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // life_start, life_finish, item_size, zero pad
	input  wire logic [0:0]  s_tuser,  // first_of_plan
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,  // assigned_offset, peak_size
	output logic [1:0]       m_tuser   // error_code
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int LMAX  = (MAX_LAYERS - 1 > 1023) ? 1023 : MAX_LAYERS - 1;
	localparam int SZ_W  = (SIZE_BITS > SIZE_W) ? SIZE_W : SIZE_BITS;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [OFS_W-1:0]   peak_q;
	logic [LAYER_W-1:0] lo_q, hi_q;
	logic [SZ_W-1:0]    size_q;
	logic [SIZE_W-1:0]  size_ext;
	logic               launch_q;
	logic [OFS_W-1:0]   res_off_q, res_peak_q;
	logic [ERR_W-1:0]   res_err_q;
	logic               m_tvalid_q;
	logic [79:0]        m_tdata_q;
	logic [1:0]         m_tuser_q;

	logic               accept, clr, ins, out_load;
	logic [LAYER_W-1:0] in_lo, in_hi;
	logic [SZ_W-1:0]    in_size;
	logic [CNT_W-1:0]   cnt_eff;
	logic [OFS_W-1:0]   peak_eff, new_end;
	cell_ctl_t          ctl;
	entry_t             new_entry;

	scan_t  scan_w  [MAX_ENTRIES+1];
	entry_t entry_w [MAX_ENTRIES+1];
	logic   valid_w [MAX_ENTRIES+1];
	logic   keep_w  [MAX_ENTRIES+1];

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign clr = accept && s_tuser[0];
	assign in_lo = ({22'd0, s_tdata[9:0]} > LMAX) ? LAYER_W'(LMAX) : s_tdata[9:0];
	assign in_hi = ({22'd0, s_tdata[19:10]} > LMAX) ? LAYER_W'(LMAX) : s_tdata[19:10];
	assign in_size = s_tdata[20 +: SZ_W];
	assign cnt_eff = s_tuser[0] ? '0 : count_q;
	assign peak_eff = s_tuser[0] ? '0 : peak_q;
	assign size_ext = SIZE_W'(size_q);

	assign new_end = sat_add(scan_w[MAX_ENTRIES].cand, size_ext);
	assign new_entry = '{lo: lo_q, hi: hi_q, base: scan_w[MAX_ENTRIES].cand, top: new_end};

	assign ctl.clr = clr;
	assign ctl.ins = ins;
	assign ctl.ins_cand = scan_w[MAX_ENTRIES].cand;

	assign scan_w[0] = '{tok: launch_q, stop: 1'b0, cand: '0};
	assign entry_w[0] = new_entry;
	assign valid_w[0] = 1'b1;
	assign keep_w[0] = 1'b1;

	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		iop_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.item_lo    (lo_q),
			.item_hi    (hi_q),
			.item_size  (size_ext),
			.scan_in    (scan_w[k]),
			.scan_out   (scan_w[k+1]),
			.prev_entry (entry_w[k]),
			.prev_valid (valid_w[k]),
			.prev_keep  (k == 0 ? 1'b1 : keep_w[k]),
			.entry      (entry_w[k+1]),
			.valid      (valid_w[k+1]),
			.keep       (keep_w[k+1])
		);
	end

	always_comb begin
		state_d = state_q;
		ins = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_hi < in_lo || in_size == '0 || cnt_eff == CNT_W'(MAX_ENTRIES)) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_w[MAX_ENTRIES].tok) begin
					ins = 1'b1;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			peak_q <= '0;
			launch_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			launch_q <= accept && (state_d == ST_SCAN);
			if (clr) begin
				count_q <= '0;
				peak_q <= '0;
			end
			if (ins) begin
				count_q <= count_q + 1'b1;
				if (new_end > peak_q) begin
					peak_q <= new_end;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= in_lo;
			hi_q <= in_hi;
			size_q <= in_size;
			res_off_q <= '0;
			res_peak_q <= peak_eff;
			if (in_hi < in_lo) begin
				res_err_q <= ERR_REVERSED;
			end else if (in_size != '0 && cnt_eff == CNT_W'(MAX_ENTRIES)) begin
				res_err_q <= ERR_FULL;
			end else begin
				res_err_q <= ERR_OK;
			end
		end
		if (ins) begin
			res_off_q <= scan_w[MAX_ENTRIES].cand;
			res_peak_q <= (new_end > peak_q) ? new_end : peak_q;
		end
		if (out_load) begin
			m_tdata_q <= {res_peak_q, res_off_q};
			m_tuser_q <= res_err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table depth");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ins |-> count_q < CNT_W'(MAX_ENTRIES))
		else $error("insert into full table");

	a_exit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_w[MAX_ENTRIES].tok |-> state_q == ST_SCAN)
		else $error("scan token left row outside scan");

	a_launch_once: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |=> !launch_q)
		else $error("scan launched twice");

endmodule
`default_nettype wire
